// ----- src/iecho_pkg.sv -----
package iecho_pkg;

  // One input beat of the frame
  typedef struct packed {
    logic [63:0] beat_data;
    logic [3:0]  beat_bytes;
    logic        last_beat;
  } in_beat_t;

  // One output beat of the frame
  typedef struct packed {
    logic [63:0] out_data;
    logic [3:0]  out_bytes;
    logic        out_last;
    logic        verdict;
  } out_beat_t;

  localparam int unsigned BEAT_LANES      = 8;
  // Header bytes snooped into flops: beats 0 to 4 cover MACs, ethertype and IPv4 header
  localparam int unsigned SNOOP_BEATS     = 5;
  localparam int unsigned SNOOP_BYTES     = SNOOP_BEATS * BEAT_LANES;
  localparam int unsigned MAC_LEN         = 6;
  localparam int unsigned IP_ADDR_LEN     = 4;
  localparam int unsigned IP_SRC_OFS      = 26;
  localparam int unsigned IP_DST_OFS      = 30;
  localparam int unsigned ETHTYPE_OFS     = 12;
  localparam int unsigned IP_VIHL_OFS     = 14;
  localparam int unsigned IP_PROTO_OFS    = 23;
  localparam int unsigned ICMP_SNOOP      = 4;

  localparam logic [7:0]  ETH_HDR_LEN       = 8'd14;
  localparam logic [7:0]  MIN_FRAME_LEN     = 8'd15;
  localparam logic [7:0]  ICMP_HDR_LEN      = 8'd8;
  localparam logic [15:0] ETHERTYPE_IPV4    = 16'h0800;
  localparam logic [7:0]  IP_PROTO_ICMP     = 8'd1;
  localparam logic [3:0]  IHL_MIN           = 4'd5;
  localparam logic [7:0]  ICMP_ECHO_REQUEST = 8'd8;
  localparam logic [7:0]  ICMP_ECHO_REPLY   = 8'd0;
  localparam logic [7:0]  ICMP_CODE_ECHO    = 8'd0;
  localparam logic [15:0] CKSUM_ADJ         = 16'h0800;
  localparam logic [3:0]  FULL_BEAT_BYTES   = 4'd8;

endpackage

// ----- src/iecho_hdr_mem.sv -----
module iecho_hdr_mem #(
  parameter int unsigned DEPTH = 10,
  parameter int unsigned AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [63:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [63:0]   rd_data
);

  logic [63:0] mem [DEPTH];
  logic [63:0] rd_data_r;

  // Write one beat, read one beat with a registered output
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/iecho_judge.sv -----
module iecho_judge
  import iecho_pkg::*;
#(
  parameter int unsigned AW = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_idx,
  input  logic [63:0]   wr_data,
  input  logic          judge_en,
  input  logic [7:0]    frame_len,
  input  logic [AW-1:0] rw_idx,
  input  logic [63:0]   rw_data,
  output logic [63:0]   rw_beat,
  output logic          verdict
);

  logic [7:0]  hb_r [SNOOP_BYTES];
  logic [7:0]  ic_r [ICMP_SNOOP];
  logic [7:0]  rw_hdr [SNOOP_BYTES];
  logic [7:0]  tgt [ICMP_SNOOP];
  logic [7:0]  off_w;
  logic [3:0]  ihl;
  logic [15:0] ethtype;
  logic        match;
  logic [16:0] sum_raw;
  logic [15:0] sum_fold;
  logic        verdict_r;
  logic [15:0] sum_r;
  logic [7:0]  off_r;

  // ICMP header position follows the IPv4 header length
  always_comb begin
    ihl     = hb_r[IP_VIHL_OFS][3:0];
    ethtype = {hb_r[ETHTYPE_OFS], hb_r[ETHTYPE_OFS+1]};
    off_w   = ETH_HDR_LEN + {2'b00, ihl, 2'b00};
    for (int m = 0; m < ICMP_SNOOP; m++) begin
      tgt[m] = off_w + 8'(m);
    end
  end

  // Match an echo request whose whole ICMP header lies inside the frame
  always_comb begin
    match = (frame_len >= MIN_FRAME_LEN) &&
            (ethtype == ETHERTYPE_IPV4) &&
            (ihl >= IHL_MIN) &&
            (hb_r[IP_PROTO_OFS] == IP_PROTO_ICMP) &&
            ((off_w + ICMP_HDR_LEN) <= frame_len) &&
            (ic_r[0] == ICMP_ECHO_REQUEST) &&
            (ic_r[1] == ICMP_CODE_ECHO);
    sum_raw  = {1'b0, ic_r[2], ic_r[3]} + {1'b0, CKSUM_ADJ};
    sum_fold = sum_raw[15:0] + 16'(sum_raw[16]);
  end

  // Snoop header bytes and the ICMP type, code and checksum as beats are written
  always_ff @(posedge clk) begin
    for (int k = 0; k < SNOOP_BYTES; k++) begin
      if (wr_en && (wr_idx == AW'(k >> 3))) begin
        hb_r[k] <= wr_data[(k & 7) * 8 +: 8];
      end
    end
    for (int m = 0; m < ICMP_SNOOP; m++) begin
      if (wr_en && (tgt[m][7:3] == 5'(wr_idx))) begin
        ic_r[m] <= wr_data[{tgt[m][2:0], 3'b000} +: 8];
      end
    end
    if (judge_en) begin
      verdict_r <= match;
      sum_r     <= sum_fold;
      off_r     <= off_w;
    end
  end

  // Swap MAC and IPv4 addresses in the snooped header
  always_comb begin
    rw_hdr = hb_r;
    for (int i = 0; i < MAC_LEN; i++) begin
      rw_hdr[i]         = hb_r[i + MAC_LEN];
      rw_hdr[i + MAC_LEN] = hb_r[i];
    end
    for (int i = 0; i < IP_ADDR_LEN; i++) begin
      rw_hdr[IP_SRC_OFS + i] = hb_r[IP_DST_OFS + i];
      rw_hdr[IP_DST_OFS + i] = hb_r[IP_SRC_OFS + i];
    end
  end

  // Patch a released beat lane by lane
  always_comb begin
    logic [7:0] kk;
    kk      = '0;
    rw_beat = rw_data;
    if (verdict_r) begin
      for (int j = 0; j < BEAT_LANES; j++) begin
        kk = 8'({rw_idx, 3'(j)});
        for (int b = 0; b < SNOOP_BEATS; b++) begin
          if (rw_idx == AW'(b)) begin
            rw_beat[j*8 +: 8] = rw_hdr[b * BEAT_LANES + j];
          end
        end
        if (kk == off_r) begin
          rw_beat[j*8 +: 8] = ICMP_ECHO_REPLY;
        end
        if (kk == off_r + 8'd2) begin
          rw_beat[j*8 +: 8] = sum_r[15:8];
        end
        if (kk == off_r + 8'd3) begin
          rw_beat[j*8 +: 8] = sum_r[7:0];
        end
      end
    end
  end

  assign verdict = verdict_r;

endmodule

// ----- src/icmp_echo_reply_rewriter.sv -----
// The first beat of a frame is registered at the output after the last buffered header beat
//   (the final beat or beat HEADER_BEATS) is accepted, through the judge state and a memory read.
// Throughput: one beat per cycle while collecting, and while releasing and streaming unless
//   out_ready holds the output; input stalls while the header buffer is judged and read.
// Reset (rst_n low, synchronous): back to collecting a header, output empty; header
//   buffer contents are left as they are.
module icmp_echo_reply_rewriter
  import iecho_pkg::*;
#(
  parameter int unsigned HEADER_BEATS = 10
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_beat
);

  localparam int unsigned AW = $clog2(HEADER_BEATS);
  localparam int unsigned CW = $clog2(HEADER_BEATS + 1);
  localparam logic [7:0]  FULL_LEN = 8'(HEADER_BEATS * 8 + 1);

  typedef enum logic [3:0] {
    ST_COLLECT = 4'b0001,
    ST_JUDGE   = 4'b0010,
    ST_RELEASE = 4'b0100,
    ST_STREAM  = 4'b1000
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] wr_idx_r, wr_idx_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic [AW-1:0] mq_idx_r, mq_idx_nxt;
  logic          mq_vld_r, mq_vld_nxt;
  logic [3:0]    fin_bytes_r, fin_bytes_nxt;
  logic          fin_last_r, fin_last_nxt;
  logic [7:0]    len_r, len_nxt;
  logic          reply_r, reply_nxt;
  logic          ovld_r, ovld_nxt;
  out_beat_t     out_r, out_nxt;

  logic          in_fire;
  logic          slot_free;
  logic          issue;
  logic          load;
  logic          mq_fin;
  logic          wr_en;
  logic          judge_en;
  logic [3:0]    byte_cnt;
  logic [63:0]   rd_data;
  logic [63:0]   rw_beat;
  logic          verdict;

  assign slot_free = !ovld_r || out_ready;
  assign in_ready  = (state_r == ST_COLLECT) || ((state_r == ST_STREAM) && slot_free);
  assign in_fire   = in_valid && in_ready;
  assign wr_en     = in_fire && (state_r == ST_COLLECT);
  assign judge_en  = (state_r == ST_JUDGE);
  assign byte_cnt  = (in_beat.beat_bytes > FULL_BEAT_BYTES) ? FULL_BEAT_BYTES
                                                             : in_beat.beat_bytes;

  // Read ahead one beat; a read issues only when its data has a place to go
  assign load   = (state_r == ST_RELEASE) && mq_vld_r && slot_free;
  assign issue  = (state_r == ST_RELEASE) && (rd_idx_r != cnt_r) && (!mq_vld_r || load);
  assign mq_fin = (CW'(mq_idx_r) == CW'(cnt_r - 1'b1));

  iecho_hdr_mem #(
    .DEPTH (HEADER_BEATS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_idx_r),
    .wr_data (in_beat.beat_data),
    .rd_en   (issue),
    .rd_addr (rd_idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  iecho_judge #(
    .AW (AW)
  ) u_judge (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_idx    (wr_idx_r),
    .wr_data   (in_beat.beat_data),
    .judge_en  (judge_en),
    .frame_len (len_r),
    .rw_idx    (mq_idx_r),
    .rw_data   (rd_data),
    .rw_beat   (rw_beat),
    .verdict   (verdict)
  );

  // Sequence collect, judge, release and stream
  always_comb begin
    state_nxt     = state_r;
    wr_idx_nxt    = wr_idx_r;
    cnt_nxt       = cnt_r;
    rd_idx_nxt    = rd_idx_r;
    mq_idx_nxt    = mq_idx_r;
    mq_vld_nxt    = mq_vld_r;
    fin_bytes_nxt = fin_bytes_r;
    fin_last_nxt  = fin_last_r;
    len_nxt       = len_r;
    reply_nxt     = reply_r;
    ovld_nxt      = ovld_r && !out_ready;
    out_nxt       = out_r;
    case (state_r)
      ST_COLLECT: begin
        if (in_fire) begin
          if (in_beat.last_beat || (wr_idx_r == AW'(HEADER_BEATS - 1))) begin
            cnt_nxt       = CW'(wr_idx_r) + 1'b1;
            fin_bytes_nxt = in_beat.beat_bytes;
            fin_last_nxt  = in_beat.last_beat;
            len_nxt       = in_beat.last_beat ? (8'({wr_idx_r, 3'b000}) + 8'(byte_cnt))
                                              : FULL_LEN;
            wr_idx_nxt    = '0;
            state_nxt     = ST_JUDGE;
          end else begin
            wr_idx_nxt = wr_idx_r + 1'b1;
          end
        end
      end
      ST_JUDGE: begin
        rd_idx_nxt = '0;
        mq_vld_nxt = 1'b0;
        state_nxt  = ST_RELEASE;
      end
      ST_RELEASE: begin
        if (load) begin
          ovld_nxt          = 1'b1;
          out_nxt.out_data  = rw_beat;
          out_nxt.out_bytes = mq_fin ? fin_bytes_r : FULL_BEAT_BYTES;
          out_nxt.out_last  = mq_fin && fin_last_r;
          out_nxt.verdict   = mq_fin && fin_last_r && verdict;
          mq_vld_nxt        = 1'b0;
          if (mq_fin) begin
            reply_nxt = verdict;
            state_nxt = fin_last_r ? ST_COLLECT : ST_STREAM;
          end
        end
        if (issue) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
          mq_idx_nxt = rd_idx_r[AW-1:0];
          mq_vld_nxt = 1'b1;
        end
      end
      ST_STREAM: begin
        if (in_fire) begin
          ovld_nxt          = 1'b1;
          out_nxt.out_data  = in_beat.beat_data;
          out_nxt.out_bytes = in_beat.beat_bytes;
          out_nxt.out_last  = in_beat.last_beat;
          out_nxt.verdict   = in_beat.last_beat && reply_r;
          if (in_beat.last_beat) begin
            state_nxt = ST_COLLECT;
          end
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  // Hold control state under reset; payload registers run free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_COLLECT;
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      mq_vld_r <= 1'b0;
      ovld_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      mq_vld_r <= mq_vld_nxt;
      ovld_r   <= ovld_nxt;
    end
    cnt_r       <= cnt_nxt;
    mq_idx_r    <= mq_idx_nxt;
    fin_bytes_r <= fin_bytes_nxt;
    fin_last_r  <= fin_last_nxt;
    len_r       <= len_nxt;
    reply_r     <= reply_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid = ovld_r;
  assign out_beat  = out_r;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import iecho_pkg::*;

  localparam int unsigned HDR_BEATS    = 10;
  localparam int unsigned DRAIN_CYCLES = HDR_BEATS + 12;
  localparam int unsigned HOLD_CYCLES  = 400;

  // Frame kinds for the stimulus generator
  localparam int unsigned FR_ECHO     = 0;
  localparam int unsigned FR_NOT_IP   = 1;
  localparam int unsigned FR_NOT_ICMP = 2;
  localparam int unsigned FR_NOT_REQ  = 3;
  localparam int unsigned FR_NOISE    = 4;

  // Streaming modes of the predictor
  localparam logic [1:0] MODE_COLLECT = 2'd0;
  localparam logic [1:0] MODE_REPLY   = 2'd1;
  localparam logic [1:0] MODE_PASS    = 2'd2;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_beat   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_beat;

  in_beat_t  beats_to_send [$];
  out_beat_t expected_beats [$];
  out_beat_t want;

  logic [63:0] hdr_store [HDR_BEATS];
  int unsigned hdr_fill    = 0;
  logic [1:0]  stream_mode = MODE_COLLECT;

  logic        in_xfer      = 1'b0;
  int unsigned total_beats  = 0;
  int unsigned beats_in     = 0;
  int unsigned beats_out    = 0;
  int unsigned frames_sent  = 0;
  int unsigned frames_out   = 0;
  int unsigned replies_out  = 0;
  int unsigned fail_count   = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;

  icmp_echo_reply_rewriter #(.HEADER_BEATS(HDR_BEATS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  always #2 clk = ~clk;

  // Byte access into the predicted header buffer; bytes past the buffer read as zero
  function automatic logic [7:0] hdr_byte(int unsigned k);
    if (k / 8 >= HDR_BEATS) return 8'h00;
    return hdr_store[k / 8][(k % 8) * 8 +: 8];
  endfunction

  function automatic void hdr_put(int unsigned k, logic [7:0] v);
    if (k / 8 < HDR_BEATS) hdr_store[k / 8][(k % 8) * 8 +: 8] = v;
  endfunction

  function automatic void hdr_swap(int unsigned a, int unsigned b, int unsigned n);
    logic [7:0] t;
    for (int unsigned i = 0; i < n; i++) begin
      t = hdr_byte(a + i);
      hdr_put(a + i, hdr_byte(b + i));
      hdr_put(b + i, t);
    end
  endfunction

  // Judge the buffered header against len bytes and rewrite it into a reply on a match
  function automatic logic echo_rewrite(int unsigned len);
    int unsigned ihl, ofs, sum;
    if (len < MIN_FRAME_LEN) return 1'b0;
    if ({hdr_byte(ETHTYPE_OFS), hdr_byte(ETHTYPE_OFS + 1)} != ETHERTYPE_IPV4) return 1'b0;
    ihl = hdr_byte(IP_VIHL_OFS) & 'hF;
    if (ihl < IHL_MIN) return 1'b0;
    ofs = ETH_HDR_LEN + ihl * 4;
    if (ofs > len) return 1'b0;
    if (hdr_byte(IP_PROTO_OFS) != IP_PROTO_ICMP) return 1'b0;
    if (ofs + ICMP_HDR_LEN > len) return 1'b0;
    if (hdr_byte(ofs) != ICMP_ECHO_REQUEST || hdr_byte(ofs + 1) != ICMP_CODE_ECHO)
      return 1'b0;
    hdr_swap(0, MAC_LEN, MAC_LEN);
    hdr_swap(IP_SRC_OFS, IP_DST_OFS, IP_ADDR_LEN);
    hdr_put(ofs, ICMP_ECHO_REPLY);
    // Add the type change back into the checksum, folding the carry around
    sum = 32'({hdr_byte(ofs + 2), hdr_byte(ofs + 3)}) + 32'(CKSUM_ADJ);
    sum = (sum & 'hFFFF) + (sum >> 16);
    hdr_put(ofs + 2, sum[15:8]);
    hdr_put(ofs + 3, sum[7:0]);
    return 1'b1;
  endfunction

  // Advance the predictor by one accepted beat and queue the beats it releases
  task automatic predict_echo_beat(in_beat_t b);
    int unsigned cnt, len;
    logic hit, fin;
    if (stream_mode == MODE_COLLECT) begin
      hdr_store[hdr_fill] = b.beat_data;
      cnt = hdr_fill + 1;
      if (!b.last_beat && cnt < HDR_BEATS) begin
        hdr_fill = cnt;
        return;
      end
      if (b.last_beat)
        len = (cnt - 1) * 8 + (b.beat_bytes > FULL_BEAT_BYTES ? 8 : b.beat_bytes);
      else
        len = HDR_BEATS * 8 + 1;
      hit = echo_rewrite(len);
      for (int unsigned i = 0; i < cnt; i++) begin
        fin = (i + 1 == cnt);
        expected_beats.push_back('{out_data:  hdr_store[i],
                                   out_bytes: fin ? b.beat_bytes : FULL_BEAT_BYTES,
                                   out_last:  fin && b.last_beat,
                                   verdict:   fin && b.last_beat && hit});
      end
      hdr_fill = 0;
      stream_mode = b.last_beat ? MODE_COLLECT : (hit ? MODE_REPLY : MODE_PASS);
    end else begin
      // Stream the beat straight through; anything but a reply counts as pass
      expected_beats.push_back('{out_data:  b.beat_data,
                                 out_bytes: b.beat_bytes,
                                 out_last:  b.last_beat,
                                 verdict:   b.last_beat && stream_mode == MODE_REPLY});
      if (b.last_beat) begin
        stream_mode = MODE_COLLECT;
        hdr_fill = 0;
      end
    end
  endtask

  // Split a frame of len bytes into beats and queue them for the driver
  task automatic add_frame(int unsigned kind, int unsigned ihl, int unsigned len, bit bad_cnt,
                           int cksum);
    logic [7:0]  fb [0:255];
    int unsigned ofs, nbeats;
    in_beat_t    b;
    ofs = ETH_HDR_LEN + ihl * 4;
    foreach (fb[i]) fb[i] = 8'($urandom);
    if (kind != FR_NOISE) begin
      {fb[ETHTYPE_OFS], fb[ETHTYPE_OFS + 1]} = ETHERTYPE_IPV4;
      if (kind == FR_NOT_IP) fb[ETHTYPE_OFS + $urandom_range(0, 1)] ^= 8'h1 << $urandom_range(0, 7);
      fb[IP_VIHL_OFS] = {($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h4, 4'(ihl)};
      fb[IP_PROTO_OFS] = IP_PROTO_ICMP;
      if (kind == FR_NOT_ICMP) fb[IP_PROTO_OFS] ^= 8'h1 << $urandom_range(0, 7);
      fb[ofs] = ICMP_ECHO_REQUEST;
      fb[ofs + 1] = ICMP_CODE_ECHO;
      if (kind == FR_NOT_REQ) fb[ofs + $urandom_range(0, 1)] ^= 8'h1 << $urandom_range(0, 7);
      if (cksum >= 0) {fb[ofs + 2], fb[ofs + 3]} = 16'(cksum);
    end
    nbeats = (len + 7) / 8;
    for (int unsigned bi = 0; bi < nbeats; bi++) begin
      for (int unsigned l = 0; l < 8; l++) b.beat_data[l * 8 +: 8] = fb[bi * 8 + l];
      b.last_beat  = (bi + 1 == nbeats);
      b.beat_bytes = b.last_beat ? 4'(len - bi * 8) : FULL_BEAT_BYTES;
      if (bad_cnt) b.beat_bytes = 4'($urandom_range(0, 15));
      beats_to_send.push_back(b);
    end
    frames_sent++;
  endtask

  function automatic int unsigned send_idle_pct();
    if (beats_in * 3 < total_beats) return 26;
    if (beats_in * 3 < total_beats * 2) return 58;
    return 0;
  endfunction

  function automatic int unsigned recv_idle_pct();
    if (beats_in * 3 < total_beats) return 58;
    if (beats_in * 3 < total_beats * 2) return 26;
    return 0;
  endfunction

  // Sample both channels: predict on an input transfer, then check an output transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_xfer <= 1'b0;
    end else begin
      in_xfer <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        predict_echo_beat(in_beat);
        beats_in++;
      end
      if (out_valid && out_ready) begin
        beats_out++;
        if (out_beat.out_last) frames_out++;
        if (out_beat.out_last && out_beat.verdict) replies_out++;
        if (expected_beats.size() == 0) begin
          $error("unexpected output beat: data %h bytes %0d last %0b verdict %0b",
                 out_beat.out_data, out_beat.out_bytes, out_beat.out_last, out_beat.verdict);
          fail_count++;
        end else begin
          want = expected_beats.pop_front();
          if (out_beat.out_data !== want.out_data) begin
            $error("out_data: expected %h, actual %h", want.out_data, out_beat.out_data);
            fail_count++;
          end
          if (out_beat.out_bytes !== want.out_bytes) begin
            $error("out_bytes: expected %0d, actual %0d", want.out_bytes, out_beat.out_bytes);
            fail_count++;
          end
          if (out_beat.out_last !== want.out_last) begin
            $error("out_last: expected %0b, actual %0b", want.out_last, out_beat.out_last);
            fail_count++;
          end
          if (out_beat.verdict !== want.verdict) begin
            $error("verdict: expected %0b, actual %0b", want.verdict, out_beat.verdict);
            fail_count++;
          end
        end
      end
    end
  end

  // Drive the input channel; hold the beat until its transfer
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_xfer)) begin
      if (beats_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
        in_beat  <= beats_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Drive out_ready; once, hold off for a long stretch so the block backs up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && beats_in >= total_beats / 5) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct());
    end
  end

  initial begin
    int unsigned r, kind, ihl, ofs, len;
    int          ck;
    bit          bad;

    // Directed: extreme single beats, checksum carry, one byte short, longer header,
    // non-IP frame and broken byte counts
    beats_to_send.push_back('{beat_data: '1, beat_bytes: FULL_BEAT_BYTES, last_beat: 1'b1});
    beats_to_send.push_back('{beat_data: '0, beat_bytes: 4'd1, last_beat: 1'b1});
    frames_sent += 2;
    add_frame(FR_ECHO, 5, 42, 1'b0, 'hFFFF);
    add_frame(FR_ECHO, 5, 41, 1'b0, -1);
    add_frame(FR_ECHO, 6, 50, 1'b0, 'h1234);
    add_frame(FR_NOT_IP, 5, 20, 1'b0, -1);
    add_frame(FR_ECHO, 5, 14, 1'b1, -1);

    // Random: mostly echo requests with random content, plus near misses and noise
    while (beats_to_send.size() < 520) begin
      r = $urandom_range(0, 99);
      kind = (r < 60) ? FR_ECHO : (r < 68) ? FR_NOT_IP : (r < 76) ? FR_NOT_ICMP :
             (r < 86) ? FR_NOT_REQ : FR_NOISE;
      ihl = ($urandom_range(0, 3) != 0) ? 5 : $urandom_range(0, 15);
      ofs = ETH_HDR_LEN + ihl * 4;
      r = $urandom_range(0, 99);
      if (r < 10) len = $urandom_range(1, ofs + 8);
      else if (r < 20) len = $urandom_range(78, 150);
      else len = ofs + 8 + $urandom_range(0, 24);
      bad = ($urandom_range(0, 11) == 0);
      ck = ($urandom_range(0, 7) == 0) ? int'($urandom_range('hF7F0, 'hFFFF)) : -1;
      add_frame(kind, ihl, len, bad, ck);
    end
    total_beats = beats_to_send.size();

    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Drain: all beats sent, all expected beats seen, then a quiet tail
    while (beats_to_send.size() != 0 || in_valid) @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d frames in %0d beats; got %0d beats, %0d frames, %0d echo replies",
             frames_sent, beats_in, beats_out, frames_out, replies_out);
    $display("covered short, oversized, non-echo and bad-count frames under back-pressure");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("timeout waiting for output beats");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
